/* hw/rtl/isbu_pkg.sv */
`timescale 1ns / 1ps

package isbu_pkg;

  // Field widths
  localparam int unsigned ColorW  = 8;
  localparam int unsigned CoordW  = 14;
  localparam int unsigned DimW    = 10;
  localparam int unsigned TileColW = 8;
  localparam int unsigned TileRowW = 10;
  localparam int unsigned PosW    = CoordW + 2;  // signed working width of a coordinate

  // Stream widths
  localparam int unsigned InDataW  = 4 * ColorW;
  localparam int unsigned OutDataW = 56;          // 52 payload bits, zero padded to bytes

  // Register port
  localparam int unsigned ApbAddrW = 5;
  localparam int unsigned ApbDataW = 32;

  // Reset values of the sprite size
  localparam logic [DimW-1:0] SpriteWidthRst  = DimW'(64);
  localparam logic [DimW-1:0] SpriteHeightRst = DimW'(32);

  // Placement constants
  localparam logic [PosW-1:0] CellOffset = PosW'(32);

  typedef enum logic [2:0] {
    RegTileColumn   = 3'd0,
    RegTileRow      = 3'd1,
    RegSpriteWidth  = 3'd2,
    RegSpriteHeight = 3'd3,
    RegImageWidth   = 3'd4,
    RegImageHeight  = 3'd5,
    RegMapColumns   = 3'd6,
    RegMapRows      = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [TileColW-1:0] tile_column;
    logic [TileRowW-1:0] tile_row;
    logic [DimW-1:0]     sprite_width;
    logic [DimW-1:0]     sprite_height;
    logic [CoordW-1:0]   image_width;
    logic [CoordW-1:0]   image_height;
    logic [TileColW-1:0] map_columns;
    logic [TileRowW-1:0] map_rows;
  } cfg_t;

  typedef struct packed {
    logic [DimW-1:0] col;
    logic [DimW-1:0] row;
    logic            done;
  } cnt_t;

  typedef struct packed {
    logic              write_enable;
    logic [CoordW-1:0] dest_x;
    logic [CoordW-1:0] dest_y;
    logic [ColorW-1:0] red;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] blue;
    logic              sprite_done;
  } res_t;

endpackage

/* hw/rtl/isbu_counter.sv */
`timescale 1ns / 1ps

module isbu_counter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  logic [isbu_pkg::DimW-1:0]    sprite_width_i,
  input  logic [isbu_pkg::DimW-1:0]    sprite_height_i,
  output isbu_pkg::cnt_t               cnt_o
);
  import isbu_pkg::*;

  logic [DimW-1:0] col_q, col_d, row_q, row_d;
  logic [DimW:0]   col_inc, row_inc;
  logic            last_col, last_row;

  // A zero size wraps on every step, same as a size of one.
  assign col_inc  = {1'b0, col_q} + (DimW+1)'(1);
  assign row_inc  = {1'b0, row_q} + (DimW+1)'(1);
  assign last_col = col_inc >= {1'b0, sprite_width_i};
  assign last_row = row_inc >= {1'b0, sprite_height_i};

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (step_i) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_inc[DimW-1:0];
      end else begin
        col_d = col_inc[DimW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign cnt_o.col  = col_q;
  assign cnt_o.row  = row_q;
  assign cnt_o.done = last_col && last_row;

  a_wrap_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && cnt_o.done |=> col_q == '0 && row_q == '0)
    else $error("counters did not wrap after last pixel");

endmodule

/* hw/rtl/isbu_calc.sv */
`timescale 1ns / 1ps

module isbu_calc (
  input  isbu_pkg::cfg_t                  cfg_i,
  input  isbu_pkg::cnt_t                  cnt_i,
  input  logic [isbu_pkg::InDataW-1:0]    pixel_i,
  output isbu_pkg::res_t                  res_o
);
  import isbu_pkg::*;

  logic [CoordW-1:0]      base_x, base_y;
  logic signed [PosW-1:0] px, py;
  logic [ColorW-1:0]      red, green, blue, alpha;
  logic                   in_map, in_img, we;

  assign red   = pixel_i[ColorW-1:0];
  assign green = pixel_i[2*ColorW-1:ColorW];
  assign blue  = pixel_i[3*ColorW-1:2*ColorW];
  assign alpha = pixel_i[4*ColorW-1:3*ColorW];

  // Staggered tile origin: 64 per column, odd rows shifted right by 32, 16 per row.
  assign base_x = {cfg_i.tile_column, cfg_i.tile_row[0], 5'b0};
  assign base_y = {cfg_i.tile_row, 4'b0};

  // Centered horizontally, bottom aligned in the 32 pixel cell.
  assign px = $signed({2'b0, base_x}) + $signed(CellOffset)
            - $signed({(PosW-DimW+1)'(0), cfg_i.sprite_width[DimW-1:1]})
            + $signed({(PosW-DimW)'(0), cnt_i.col});
  assign py = $signed({2'b0, base_y}) + $signed(CellOffset)
            - $signed({(PosW-DimW)'(0), cfg_i.sprite_height})
            + $signed({(PosW-DimW)'(0), cnt_i.row});

  assign in_map = (cfg_i.tile_column <= cfg_i.map_columns) &&
                  (cfg_i.tile_row <= cfg_i.map_rows);
  assign in_img = !px[PosW-1] && !py[PosW-1] &&
                  (px < $signed({2'b0, cfg_i.image_width})) &&
                  (py < $signed({2'b0, cfg_i.image_height}));
  assign we = (alpha != '0) && in_map && in_img;

  always_comb begin
    res_o              = '0;
    res_o.sprite_done  = cnt_i.done;
    if (we) begin
      res_o.write_enable = 1'b1;
      res_o.dest_x       = px[CoordW-1:0];
      res_o.dest_y       = py[CoordW-1:0];
      res_o.red          = red;
      res_o.green        = green;
      res_o.blue         = blue;
    end
  end

endmodule

/* hw/rtl/isbu_out_buf.sv */
`timescale 1ns / 1ps

module isbu_out_buf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  isbu_pkg::res_t in_res_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output isbu_pkg::res_t out_res_o
);
  import isbu_pkg::*;

  res_t out_q, out_d, skid_q, skid_d;
  logic out_vld_q, out_vld_d, skid_vld_q, skid_vld_d;
  logic in_acc, out_load;

  assign in_ready_o = !skid_vld_q;
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_load   = !out_vld_q || out_ready_i;

  always_comb begin
    out_d      = out_q;
    out_vld_d  = out_vld_q;
    skid_d     = skid_q;
    skid_vld_d = skid_vld_q;
    if (out_load) begin
      if (skid_vld_q) begin
        out_d      = skid_q;
        out_vld_d  = 1'b1;
        skid_vld_d = 1'b0;
      end else begin
        out_d     = in_res_i;
        out_vld_d = in_acc;
      end
    end else if (in_acc) begin
      // Output is stalled: park the new item.
      skid_d     = in_res_i;
      skid_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_res_o   = out_q;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid holds an item while output is empty");

endmodule

/* hw/rtl/isometric_sprite_blitter_unit.sv */
`timescale 1ns / 1ps

// Isometric sprite blitter.
// Input stream (s_axis): one RGBA sprite pixel per item, raster order. The
// block keeps its own column/row counters, so the first item after reset (or
// after the previous sprite's last pixel) is the sprite's top-left pixel.
// Output stream (m_axis): one item per input item, carrying the destination
// coordinates and color; tuser is the write enable, tlast marks the sprite's
// last pixel. When the write is disabled all tdata bits are zero.
// Register port (APB): tile position, sprite size, image size and map bounds
// at byte addresses 0, 4, ..., 28. Write registers only while the block is idle.
// Path: an accepted item goes to the output register, or to the skid stage while
// m_axis is stalled. Throughput: one item per cycle unless m_axis stalls; the
// placement math is a few narrow adds and compares feeding the output register.
// Stall: a one-entry skid stage behind the output register takes one more item
// while m_axis is stalled; s_axis_tready then drops until the output drains.
// Reset: counters clear, sprite size returns to 64x32, other registers to 0,
// both stream stages empty.
module isometric_sprite_blitter_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // APB register port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [isbu_pkg::ApbAddrW-1:0]    paddr,
  input  logic [isbu_pkg::ApbDataW-1:0]    pwdata,
  output logic [isbu_pkg::ApbDataW-1:0]    prdata,
  output logic                             pready,
  // Sprite pixel input
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [isbu_pkg::InDataW-1:0]     s_axis_tdata,  // src_red, src_green, src_blue, src_alpha
  // Placed pixel output
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [isbu_pkg::OutDataW-1:0]    m_axis_tdata,  // dest_x, dest_y, out_red, out_green,
                                                          // out_blue, zero pad
  output logic                             m_axis_tuser,  // write_enable
  output logic                             m_axis_tlast   // sprite_done
);
  import isbu_pkg::*;

  // Register values after reset
  localparam cfg_t CfgRst = {TileColW'(0), TileRowW'(0), SpriteWidthRst, SpriteHeightRst,
                             CoordW'(0), CoordW'(0), TileColW'(0), TileRowW'(0)};

  cfg_t     cfg_q, cfg_d;
  cnt_t     cnt;
  res_t     res_in, res_out;
  reg_idx_e reg_idx;
  logic     cfg_wr;
  logic     in_acc;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[ApbAddrW-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      case (reg_idx)
        RegTileColumn:   cfg_d.tile_column   = pwdata[TileColW-1:0];
        RegTileRow:      cfg_d.tile_row      = pwdata[TileRowW-1:0];
        RegSpriteWidth:  cfg_d.sprite_width  = pwdata[DimW-1:0];
        RegSpriteHeight: cfg_d.sprite_height = pwdata[DimW-1:0];
        RegImageWidth:   cfg_d.image_width   = pwdata[CoordW-1:0];
        RegImageHeight:  cfg_d.image_height  = pwdata[CoordW-1:0];
        RegMapColumns:   cfg_d.map_columns   = pwdata[TileColW-1:0];
        RegMapRows:      cfg_d.map_rows      = pwdata[TileRowW-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegTileColumn:   prdata = ApbDataW'(cfg_q.tile_column);
      RegTileRow:      prdata = ApbDataW'(cfg_q.tile_row);
      RegSpriteWidth:  prdata = ApbDataW'(cfg_q.sprite_width);
      RegSpriteHeight: prdata = ApbDataW'(cfg_q.sprite_height);
      RegImageWidth:   prdata = ApbDataW'(cfg_q.image_width);
      RegImageHeight:  prdata = ApbDataW'(cfg_q.image_height);
      RegMapColumns:   prdata = ApbDataW'(cfg_q.map_columns);
      RegMapRows:      prdata = ApbDataW'(cfg_q.map_rows);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign in_acc = s_axis_tvalid && s_axis_tready;

  // Counters step on every accepted pixel; the result uses the pre-step values.
  isbu_counter u_counter (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (in_acc),
    .sprite_width_i  (cfg_q.sprite_width),
    .sprite_height_i (cfg_q.sprite_height),
    .cnt_o           (cnt)
  );

  isbu_calc u_calc (
    .cfg_i   (cfg_q),
    .cnt_i   (cnt),
    .pixel_i (s_axis_tdata),
    .res_o   (res_in)
  );

  isbu_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_res_i    (res_in),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res_out)
  );

  assign m_axis_tdata = {4'b0, res_out.blue, res_out.green, res_out.red,
                         res_out.dest_y, res_out.dest_x};
  assign m_axis_tuser = res_out.write_enable;
  assign m_axis_tlast = res_out.sprite_done;

  a_disabled_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("disabled write carries nonzero data");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && $past(m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a waiting output");

  a_item_reaches_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> m_axis_tvalid)
    else $error("accepted item did not produce an output");

endmodule
